### hw/rtl/wqa_pkg.sv
// Shared types, codes and widths of the waypoint queue advancer.
package wqa_pkg;

   localparam int COORD_W = 24;
   localparam int THR_W   = 23;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W + 1;
   localparam int DIST_W  = SQ_W + 1;
   localparam int T2_W    = 2 * THR_W;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PUSH  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NONE  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [COORD_W-1:0] goal_x;
      logic signed [COORD_W-1:0] goal_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_SQUARE,
      S_DECIDE,
      S_HOLD
   } state_type;

endpackage

### hw/rtl/wqa_dist.sv
// Two-stage squared-distance check of a stored point against the position.
module wqa_dist
   import wqa_pkg::*;
(
   input  logic             clock,
   input  point_type        point,
   input  point_type        pos,
   input  logic [T2_W-1:0]  t2,
   output logic             far
);

   logic signed [DIFF_W-1:0]   dx;
   logic signed [DIFF_W-1:0]   dy;
   logic signed [2*DIFF_W-1:0] prod_x;
   logic signed [2*DIFF_W-1:0] prod_y;
   logic [SQ_W-1:0]            sqx_ff;
   logic [SQ_W-1:0]            sqy_ff;
   logic [DIST_W-1:0]          sum;

   assign dx     = DIFF_W'(pos.x) - DIFF_W'(point.x);
   assign dy     = DIFF_W'(pos.y) - DIFF_W'(point.y);
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   // squares are never negative and stay below 2**48
   always_ff @(posedge clock) begin
      sqx_ff <= prod_x[SQ_W-1:0];
      sqy_ff <= prod_y[SQ_W-1:0];
   end

   assign sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign far = sum >= DIST_W'(t2);

endmodule

### hw/rtl/waypoint_queue_advancer.sv
// Top level of the waypoint queue advancer: FIFO memory, sequencer, output register.
//
// Input words arrive on req_valid/req_ready with a command, and x/y in 1/256 m.
// Every word yields exactly one response word on rsp_valid/rsp_ready.
// Clear, push and unused codes finish in the accept cycle; their response is
// registered, or parked while the output register is full. A full-queue push
// answers with the full status and drops the point; a query on an empty queue
// answers empty. For each queue entry that it examines, a query steps through
// fetch, square and decide: memory read, squaring, then compare and pop, all
// through the single read port of the point memory.
// The next word is accepted once the sequencer is idle, even while the last
// response still waits; a response that finds the output register full is
// held in a pending register and the input then stalls until it moves on.
// Reset empties the queue (head and count to zero) and sets the threshold to
// 256 (1 m); the point memory is not cleared, and no pass runs after reset.
// The threshold port csr_wr_en/csr_wr_data also acts on a query already running.
module waypoint_queue_advancer
   import wqa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_word,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   point_type        mem [QUEUE_DEPTH];
   point_type        rd_data_ff;
   logic             rd_en;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pass2_ff, pass2_in;
   point_type        pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;
   rsp_type          pend_ff, pend_in;
   logic [THR_W-1:0] thr_ff;
   logic [T2_W-1:0]  t2_ff;

   logic             far;
   logic             out_free;
   logic             res_valid;
   rsp_type          res;
   logic             pop;
   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] head_next;

   // threshold register and its square
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      t2_ff <= thr_ff * thr_ff;
   end

   // point memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= point_type'({req_word.coord_x, req_word.coord_y});
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   wqa_dist u_dist (
      .clock (clock),
      .point (rd_data_ff),
      .pos   (pos_ff),
      .t2    (t2_ff),
      .far   (far)
   );

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx  = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                              : tail_sum[IDX_W-1:0];
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pass2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pass2_ff     <= pass2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rsp_word_ff <= rsp_word_in;
      pend_ff     <= pend_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pass2_in     = pass2_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = tail_idx;
      res_valid    = 1'b0;
      res          = '0;
      pop          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_word.command)
                  CMD_CLEAR: begin
                     head_in   = '0;
                     count_in  = '0;
                     res_valid = 1'b1;
                  end
                  CMD_PUSH: begin
                     res_valid = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        res.status = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + ONE_CNT;
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                     end else begin
                        pos_in   = point_type'({req_word.coord_x, req_word.coord_y});
                        pass2_in = 1'b0;
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!pass2_ff && far) begin
               // first pass: drop points already out of reach
               pop = 1'b1;
               if (count_ff == ONE_CNT) begin
                  res_valid  = 1'b1;
                  res.status = ST_NONE;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               pass2_in = 1'b1;
               if (count_ff > ONE_CNT && !far) begin
                  // second pass: drop near points while one would remain
                  pop      = 1'b1;
                  state_in = S_FETCH;
               end else begin
                  res_valid  = 1'b1;
                  res.goal_x = rd_data_ff.x;
                  res.goal_y = rd_data_ff.y;
               end
            end
            if (pop) begin
               head_in  = head_next;
               count_in = count_ff - ONE_CNT;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_word_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the word to the output register, or park it while that is full
      if (res_valid) begin
         if (out_free) begin
            rsp_word_in  = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond queue depth");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("pending response with empty output register");

   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> count_ff != '0)
      else $error("fetch from empty queue");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && pop) |=> count_ff == $past(count_ff) - ONE_CNT)
      else $error("pop did not reduce entry count");

endmodule
